FILE: rtl/sgm_pkg.sv
// ----------------------------------------------------------------------------
// sgm_pkg
// Shared types and codes of the stroke glyph to motion command converter.
// ----------------------------------------------------------------------------
`default_nettype none

package sgm_pkg;

  // Result command codes
  localparam logic [1:0] CMD_RETRACT   = 2'd0;
  localparam logic [1:0] CMD_PLUNGE    = 2'd1;
  localparam logic [1:0] CMD_XY_MOVE   = 2'd2;
  localparam logic [1:0] CMD_GLYPH_END = 2'd3;

  // Motion word codes of an XY move
  localparam logic [1:0] MW_MODAL = 2'd0;
  localparam logic [1:0] MW_RAPID = 2'd1;
  localparam logic [1:0] MW_FEED  = 2'd2;

  // Configuration register indexes (byte address is 4 * index)
  localparam int unsigned APB_ADDR_W = 5;
  localparam logic [2:0] REG_SCALE   = 3'd0;
  localparam logic [2:0] REG_ALIGN_X = 3'd1;
  localparam logic [2:0] REG_ALIGN_Y = 3'd2;
  localparam logic [2:0] REG_COS     = 3'd3;
  localparam logic [2:0] REG_SIN     = 3'd4;
  localparam logic [2:0] REG_ORG_X   = 3'd5;
  localparam logic [2:0] REG_ORG_Y   = 3'd6;

  // Stream widths that do not depend on parameters
  localparam int unsigned IN_TUSER_W  = 3;
  localparam int unsigned OUT_TUSER_W = 5;
  localparam int unsigned OUT_TDATA_W = 64;

  // Operand pair of the shared multiplier
  typedef enum logic [2:0] {
    MUL_GX,
    MUL_GY,
    MUL_COS_AX,
    MUL_SIN_AX,
    MUL_SIN_AY,
    MUL_COS_AY
  } mul_sel_e;

  typedef struct packed {
    logic [23:0] scale;
    logic [31:0] align_x;
    logic [31:0] align_y;
    logic [15:0] cos_rot;
    logic [15:0] sin_rot;
    logic [31:0] origin_x;
    logic [31:0] origin_y;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [1:0]  motion_word;
    logic        cut_feed;
    logic [31:0] out_x;
    logic [31:0] out_y;
    logic        last;
  } result_t;

  // Controller to datapath commands
  typedef struct packed {
    logic     accept;
    mul_sel_e mul_sel;
    logic     ld_px;
    logic     ld_py;
    logic     ld_ay;
    logic     accx_init;
    logic     accy_init;
    logic     accx_sub;
    logic     accy_add;
    logic     emit_pre;
    logic     emit_main;
  } ctrl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic in_segment;
    logic ending;
    logic pre_valid;
  } dp_status_t;

endpackage

`default_nettype wire

FILE: rtl/sgm_cfg_regs.sv
// ----------------------------------------------------------------------------
// sgm_cfg_regs
// APB register file holding scale, alignment, rotation and origin.
// ----------------------------------------------------------------------------
`default_nettype none

module sgm_cfg_regs (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [sgm_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [31:0]                    pwdata,
  output logic      [31:0]                    prdata,
  output logic                                pready,
  output sgm_pkg::cfg_t                       cfg_o
);
  import sgm_pkg::*;

  cfg_t       cfg_q;
  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;
  assign reg_idx = paddr[APB_ADDR_W-1:2];
  assign cfg_o   = cfg_q;

  // Write on the access phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.scale    <= 24'd65536;
      cfg_q.align_x  <= '0;
      cfg_q.align_y  <= '0;
      cfg_q.cos_rot  <= 16'd16384;
      cfg_q.sin_rot  <= '0;
      cfg_q.origin_x <= '0;
      cfg_q.origin_y <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_SCALE:   cfg_q.scale    <= pwdata[23:0];
        REG_ALIGN_X: cfg_q.align_x  <= pwdata;
        REG_ALIGN_Y: cfg_q.align_y  <= pwdata;
        REG_COS:     cfg_q.cos_rot  <= pwdata[15:0];
        REG_SIN:     cfg_q.sin_rot  <= pwdata[15:0];
        REG_ORG_X:   cfg_q.origin_x <= pwdata;
        REG_ORG_Y:   cfg_q.origin_y <= pwdata;
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (reg_idx)
      REG_SCALE:   prdata = {8'd0, cfg_q.scale};
      REG_ALIGN_X: prdata = cfg_q.align_x;
      REG_ALIGN_Y: prdata = cfg_q.align_y;
      REG_COS:     prdata = {16'd0, cfg_q.cos_rot};
      REG_SIN:     prdata = {16'd0, cfg_q.sin_rot};
      REG_ORG_X:   prdata = cfg_q.origin_x;
      REG_ORG_Y:   prdata = cfg_q.origin_y;
      default:     prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/sgm_ctrl.sv
// ----------------------------------------------------------------------------
// sgm_ctrl
// Sequencer: steps the shared multiplier through scale and rotation and
// hands results to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sgm_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire sgm_pkg::dp_status_t status_i,
  input  wire logic                slot_free_i,
  output sgm_pkg::ctrl_cmd_t       cmd_o
);
  import sgm_pkg::*;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_MGX  = 4'd1;
  localparam logic [3:0] ST_MGY  = 4'd2;
  localparam logic [3:0] ST_PY   = 4'd3;
  localparam logic [3:0] ST_AY   = 4'd4;
  localparam logic [3:0] ST_R1   = 4'd5;
  localparam logic [3:0] ST_R2   = 4'd6;
  localparam logic [3:0] ST_R3   = 4'd7;
  localparam logic [3:0] ST_R4   = 4'd8;
  localparam logic [3:0] ST_PRE  = 4'd9;
  localparam logic [3:0] ST_MAIN = 4'd10;

  logic [3:0] state_q, state_d;

  assign in_ready_o = (state_q == ST_IDLE);

  // Next state and datapath commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (status_i.in_segment) state_d = ST_MGX;
        end
      end
      ST_MGX: begin
        cmd_o.mul_sel = MUL_GX;
        state_d       = ST_MGY;
      end
      ST_MGY: begin
        cmd_o.mul_sel = MUL_GY;
        cmd_o.ld_px   = 1'b1;
        state_d       = ST_PY;
      end
      ST_PY: begin
        cmd_o.ld_py = 1'b1;
        if (status_i.ending) state_d = status_i.pre_valid ? ST_PRE : ST_MAIN;
        else                 state_d = ST_AY;
      end
      ST_AY: begin
        cmd_o.mul_sel = MUL_COS_AX;
        cmd_o.ld_ay   = 1'b1;
        state_d       = ST_R1;
      end
      ST_R1: begin
        cmd_o.mul_sel   = MUL_SIN_AX;
        cmd_o.accx_init = 1'b1;
        state_d         = ST_R2;
      end
      ST_R2: begin
        cmd_o.mul_sel   = MUL_SIN_AY;
        cmd_o.accy_init = 1'b1;
        state_d         = ST_R3;
      end
      ST_R3: begin
        cmd_o.mul_sel  = MUL_COS_AY;
        cmd_o.accx_sub = 1'b1;
        state_d        = ST_R4;
      end
      ST_R4: begin
        cmd_o.accy_add = 1'b1;
        state_d        = status_i.pre_valid ? ST_PRE : ST_MAIN;
      end
      ST_PRE: begin
        if (slot_free_i) begin
          cmd_o.emit_pre = 1'b1;
          state_d        = ST_MAIN;
        end
      end
      ST_MAIN: begin
        if (slot_free_i) begin
          cmd_o.emit_main = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else         state_q <= state_d;
  end

endmodule

`default_nettype wire

FILE: rtl/sgm_datapath.sv
// ----------------------------------------------------------------------------
// sgm_datapath
// Cursor and segment state, one shared registered multiplier, saturating
// adders and the rotation accumulators.
// ----------------------------------------------------------------------------
`default_nettype none

module sgm_datapath #(
  parameter int unsigned GLYPH_COORD_BITS = 8,
  parameter int unsigned POSITION_BITS    = 32
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire sgm_pkg::ctrl_cmd_t                 cmd_i,
  output sgm_pkg::dp_status_t                     status_o,
  input  wire sgm_pkg::cfg_t                      cfg_i,
  input  wire logic                               operation_i,
  input  wire logic                               draw_i,
  input  wire logic                               first_of_glyph_i,
  input  wire logic                               last_of_glyph_i,
  input  wire logic signed [GLYPH_COORD_BITS-1:0] glyph_x_i,
  input  wire logic signed [GLYPH_COORD_BITS-1:0] glyph_y_i,
  input  wire logic signed [31:0]                 line_start_x_i,
  input  wire logic signed [31:0]                 line_start_y_i,
  output sgm_pkg::result_t                        result_o
);
  import sgm_pkg::*;

  localparam int unsigned G  = GLYPH_COORD_BITS;
  localparam int unsigned P  = POSITION_BITS;
  localparam int unsigned MA = (P > G) ? P : G;         // multiplier operand A
  localparam int unsigned PW = MA + 25;                  // product
  localparam int unsigned SW = PW + 1;                   // product plus cursor
  localparam int unsigned LW = (P > 32) ? P : 32;        // wider of position and 32
  localparam int unsigned AW = LW + 1;                   // position plus alignment
  localparam int unsigned CW = ((PW + 2) > 48) ? (PW + 2) : 48;  // accumulators
  localparam int unsigned RW = CW - 14;                  // rounded rotation

  localparam logic signed [P-1:0] P_MAX     = {1'b0, {(P-1){1'b1}}};
  localparam logic signed [P-1:0] P_MIN     = {1'b1, {(P-1){1'b0}}};
  localparam logic signed [P-1:0] P_MIN_SYM = {1'b1, {(P-2){1'b0}}, 1'b1};

  // Saturate to the position range
  function automatic logic signed [P-1:0] sat_s(input logic signed [SW-1:0] v);
    if (v > SW'(P_MAX))      return P_MAX;
    else if (v < SW'(P_MIN)) return P_MIN;
    else                     return P'(v);
  endfunction

  function automatic logic signed [P-1:0] sat_l(input logic signed [LW-1:0] v);
    if (v > LW'(P_MAX))      return P_MAX;
    else if (v < LW'(P_MIN)) return P_MIN;
    else                     return P'(v);
  endfunction

  function automatic logic signed [P-1:0] sat_a(input logic signed [AW-1:0] v);
    if (v > AW'(P_MAX))          return P_MAX;
    else if (v < AW'(P_MIN_SYM)) return P_MIN_SYM;
    else                         return P'(v);
  endfunction

  function automatic logic signed [P-1:0] sat_r(input logic signed [RW-1:0] v);
    if (v > RW'(P_MAX))      return P_MAX;
    else if (v < RW'(P_MIN)) return P_MIN;
    else                     return P'(v);
  endfunction

  // Segment state
  logic signed [P-1:0] cursor_x_q, cursor_y_q;
  logic                prev_draw_q, have_prev_q, first_pend_q;
  logic                ending_q, pre_valid_q, pre_plunge_q;
  logic [1:0]          mw_q;
  logic signed [G-1:0] gx_q, gy_q;

  // Arithmetic registers
  logic signed [PW-1:0] prod_q;
  logic signed [P-1:0]  px_q, py_q, ax_q, ay_q;
  logic signed [CW-1:0] accx_q, accy_q;

  logic signed [MA-1:0] mul_a;
  logic signed [24:0]   mul_b;
  logic signed [PW-1:0] mul_res;
  logic signed [P-1:0]  py_d;
  logic signed [CW-1:0] bias_x, bias_y;
  logic signed [P-1:0]  ox_p, oy_p;
  logic signed [LW-1:0] ox_w, oy_w;
  logic                 hp_eff, fp_eff;

  assign status_o.in_segment = operation_i;
  assign status_o.ending     = ending_q;
  assign status_o.pre_valid  = pre_valid_q;

  // Operand select of the shared multiplier
  always_comb begin
    case (cmd_i.mul_sel)
      MUL_GX: begin
        mul_a = MA'(gx_q);
        mul_b = {1'b0, cfg_i.scale};
      end
      MUL_GY: begin
        mul_a = MA'(gy_q);
        mul_b = {1'b0, cfg_i.scale};
      end
      MUL_COS_AX: begin
        mul_a = MA'(ax_q);
        mul_b = 25'($signed(cfg_i.cos_rot));
      end
      MUL_SIN_AX: begin
        mul_a = MA'(ax_q);
        mul_b = 25'($signed(cfg_i.sin_rot));
      end
      MUL_SIN_AY: begin
        mul_a = MA'(ay_q);
        mul_b = 25'($signed(cfg_i.sin_rot));
      end
      MUL_COS_AY: begin
        mul_a = MA'(ay_q);
        mul_b = 25'($signed(cfg_i.cos_rot));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_res = mul_a * mul_b;

  always_ff @(posedge clk_i) begin
    prod_q <= mul_res;
  end

  // Origin folded into the accumulator start, with the half-LSB rounding term
  assign bias_x = {RW'($signed(cfg_i.origin_x)), 14'h2000};
  assign bias_y = {RW'($signed(cfg_i.origin_y)), 14'h2000};

  assign py_d = sat_s(SW'(prod_q) + SW'(cursor_y_q));

  // Scale, align and rotate
  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_px) px_q <= sat_s(SW'(prod_q) + SW'(cursor_x_q));
    if (cmd_i.ld_py) begin
      py_q <= py_d;
      ax_q <= sat_a(AW'(px_q) + AW'($signed(cfg_i.align_x)));
    end
    if (cmd_i.ld_ay)     ay_q   <= sat_a(AW'(py_q) + AW'($signed(cfg_i.align_y)));
    if (cmd_i.accx_init) accx_q <= CW'(prod_q) + bias_x;
    if (cmd_i.accx_sub)  accx_q <= accx_q - CW'(prod_q);
    if (cmd_i.accy_init) accy_q <= CW'(prod_q) + bias_y;
    if (cmd_i.accy_add)  accy_q <= accy_q + CW'(prod_q);
  end

  // Latch the segment fields on accept
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && operation_i) begin
      gx_q         <= glyph_x_i;
      gy_q         <= glyph_y_i;
      ending_q     <= last_of_glyph_i;
      pre_valid_q  <= hp_eff & (draw_i ^ prev_draw_q);
      pre_plunge_q <= draw_i;
      mw_q         <= fp_eff ? (draw_i ? MW_FEED : MW_RAPID) : MW_MODAL;
    end
  end

  assign hp_eff = have_prev_q & ~first_of_glyph_i;
  assign fp_eff = first_pend_q | first_of_glyph_i;

  // Cursor and pen history
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_x_q   <= '0;
      cursor_y_q   <= '0;
      prev_draw_q  <= 1'b0;
      have_prev_q  <= 1'b0;
      first_pend_q <= 1'b1;
    end else begin
      if (cmd_i.accept) begin
        if (!operation_i) begin
          cursor_x_q   <= sat_l(LW'(line_start_x_i));
          cursor_y_q   <= sat_l(LW'(line_start_y_i));
          have_prev_q  <= 1'b0;
          first_pend_q <= 1'b1;
        end else begin
          prev_draw_q  <= draw_i;
          have_prev_q  <= ~last_of_glyph_i;
          first_pend_q <= last_of_glyph_i;
        end
      end
      // Advance the cursor at glyph end
      if (cmd_i.ld_py && ending_q) begin
        cursor_x_q <= px_q;
        cursor_y_q <= py_d;
      end
    end
  end

  // Round, saturate and narrow the rotated position
  assign ox_p = sat_r(RW'(accx_q >>> 14));
  assign oy_p = sat_r(RW'(accy_q >>> 14));
  assign ox_w = LW'(ox_p);
  assign oy_w = LW'(oy_p);

  // Result word for the output register
  always_comb begin
    result_o = '0;
    if (cmd_i.emit_pre) begin
      result_o.command = pre_plunge_q ? CMD_PLUNGE : CMD_RETRACT;
    end else if (ending_q) begin
      result_o.command = CMD_GLYPH_END;
      result_o.last    = 1'b1;
    end else begin
      result_o.command     = CMD_XY_MOVE;
      result_o.motion_word = mw_q;
      result_o.cut_feed    = pre_valid_q & pre_plunge_q;
      result_o.out_x       = ox_w[31:0];
      result_o.out_y       = oy_w[31:0];
      result_o.last        = 1'b1;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/sgm_out_reg.sv
// ----------------------------------------------------------------------------
// sgm_out_reg
// Output register of the result stream; frees the sequencer while a
// result waits for the sink.
// ----------------------------------------------------------------------------
`default_nettype none

module sgm_out_reg (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             load_i,
  input  wire sgm_pkg::result_t result_i,
  output logic                  slot_free_o,
  output logic                  valid_o,
  input  wire logic             ready_i,
  output sgm_pkg::result_t      result_o
);
  import sgm_pkg::*;

  logic    valid_q;
  result_t data_q;

  assign slot_free_o = ~valid_q | ready_i;
  assign valid_o     = valid_q;
  assign result_o    = data_q;

  // Hold until the beat is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)          valid_q <= 1'b0;
    else if (load_i)      valid_q <= 1'b1;
    else if (ready_i)     valid_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (load_i) data_q <= result_i;
  end

endmodule

`default_nettype wire

FILE: rtl/stroke_glyph_to_motion_commands.sv
// ----------------------------------------------------------------------------
// stroke_glyph_to_motion_commands
// Turns stroke-font glyph segments into retract, plunge, XY move and
// glyph-end commands, scaling, aligning and rotating each point.
// ----------------------------------------------------------------------------
//  Channel   Direction  Beat
//  s_axis    in         cursor set or glyph segment (tlast = glyph end)
//  m_axis    out        one command (tlast = last of its segment)
//  APB       in/out     seven configuration registers at 4*index
//
//  A cursor set needs no multiplier pass. Glyph ends take the two scale passes
//  and other segments six passes through the single shared multiplier
//  (two scale, four rotation) and their accumulate steps.
//  A finished result waits in the output register; the next input beat is
//  taken meanwhile, and a stall only holds the sequencer at its emit step.
//  Reset restores the register defaults and the cursor to zero.
// ----------------------------------------------------------------------------
`default_nettype none

module stroke_glyph_to_motion_commands #(
  parameter int unsigned GLYPH_COORD_BITS = 8,
  parameter int unsigned POSITION_BITS    = 32
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // Input stream
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // glyph_x, glyph_y, line_start_x, line_start_y, zero fill
  input  wire logic [((2 * GLYPH_COORD_BITS + 64 + 7) / 8) * 8 - 1:0] s_axis_tdata,
  // operation, draw, first_of_glyph
  input  wire logic [sgm_pkg::IN_TUSER_W-1:0]    s_axis_tuser,
  input  wire logic                              s_axis_tlast,
  // Output stream
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // out_x, out_y
  output logic [sgm_pkg::OUT_TDATA_W-1:0]        m_axis_tdata,
  // command, motion_word, cut_feed
  output logic [sgm_pkg::OUT_TUSER_W-1:0]        m_axis_tuser,
  output logic                                   m_axis_tlast,
  // Configuration
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [sgm_pkg::APB_ADDR_W-1:0]    paddr,
  input  wire logic [31:0]                       pwdata,
  output logic      [31:0]                       prdata,
  output logic                                   pready
);
  import sgm_pkg::*;

  localparam int unsigned G = GLYPH_COORD_BITS;

  cfg_t       cfg;
  ctrl_cmd_t  cmd;
  dp_status_t status;
  result_t    res_d, res_q;
  logic       slot_free;

  sgm_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  sgm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .status_i    (status),
    .slot_free_i (slot_free),
    .cmd_o       (cmd)
  );

  sgm_datapath #(
    .GLYPH_COORD_BITS (GLYPH_COORD_BITS),
    .POSITION_BITS    (POSITION_BITS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .cfg_i            (cfg),
    .operation_i      (s_axis_tuser[0]),
    .draw_i           (s_axis_tuser[1]),
    .first_of_glyph_i (s_axis_tuser[2]),
    .last_of_glyph_i  (s_axis_tlast),
    .glyph_x_i        ($signed(s_axis_tdata[G-1:0])),
    .glyph_y_i        ($signed(s_axis_tdata[2*G-1:G])),
    .line_start_x_i   ($signed(s_axis_tdata[2*G+31:2*G])),
    .line_start_y_i   ($signed(s_axis_tdata[2*G+63:2*G+32])),
    .result_o         (res_d)
  );

  sgm_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (cmd.emit_pre | cmd.emit_main),
    .result_i    (res_d),
    .slot_free_o (slot_free),
    .valid_o     (m_axis_tvalid),
    .ready_i     (m_axis_tready),
    .result_o    (res_q)
  );

  // Pack the result beat
  assign m_axis_tdata = {res_q.out_y, res_q.out_x};
  assign m_axis_tuser = {res_q.cut_feed, res_q.motion_word, res_q.command};
  assign m_axis_tlast = res_q.last;

endmodule

`default_nettype wire

FILE: rtl/sgm_checker.sv
// ----------------------------------------------------------------------------
// sgm_checker
// Port-level checks on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module sgm_checker (
  input wire logic                             clk_i,
  input wire logic                             rst_ni,
  input wire logic                             m_axis_tvalid,
  input wire logic                             m_axis_tready,
  input wire logic [sgm_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  input wire logic [sgm_pkg::OUT_TUSER_W-1:0]  m_axis_tuser,
  input wire logic                             m_axis_tlast
);
  import sgm_pkg::*;

  logic [1:0] cmd;
  logic [1:0] mw;
  logic       cf;

  assign cmd = m_axis_tuser[1:0];
  assign mw  = m_axis_tuser[3:2];
  assign cf  = m_axis_tuser[4];

  // Hold a stalled beat
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
    && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("stalled result beat changed");

  // Only retract and plunge precede another result of the same segment
  a_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> cmd == CMD_RETRACT || cmd == CMD_PLUNGE)
    else $error("non-final result is not a retract or plunge");

  // Coordinates and motion fields appear only on XY moves
  a_zero_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && cmd != CMD_XY_MOVE |-> m_axis_tdata == '0 && mw == MW_MODAL && !cf)
    else $error("non-move result carries position or motion fields");

  // Retract and plunge close nothing, moves and glyph ends always close
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (cmd == CMD_XY_MOVE || cmd == CMD_GLYPH_END) |-> m_axis_tlast)
    else $error("move or glyph end without last");

endmodule

bind stroke_glyph_to_motion_commands sgm_checker u_sgm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

FILE: tb/sv/tb_stroke_glyph_to_motion_commands.sv
// ----------------------------------------------------------------------------
// tb_stroke_glyph_to_motion_commands
// Self-checking bench for the stroke glyph to motion command converter.
// Directed glyphs cover pen transitions, glyph ends and saturation. Random
// glyph runs follow under several register settings, with random gaps on
// the input and random stalls on the output. Every command beat is checked
// against a bit-exact prediction of the scale, align, rotate and offset path.
// ----------------------------------------------------------------------------
module tb_stroke_glyph_to_motion_commands;
  import sgm_pkg::*;

  localparam int unsigned IN_DATA_W  = 80;
  localparam int unsigned SETTLE_CYC = 24;
  localparam int unsigned RAND_ITEMS = 400;

  typedef struct {
    bit                 op;
    bit                 draw;
    bit                 glyph_first;
    bit                 glyph_last;
    logic signed [7:0]  glyph_x;
    logic signed [7:0]  glyph_y;
    logic signed [31:0] line_x;
    logic signed [31:0] line_y;
  } glyph_item_t;

  // Predicts the command beats of each accepted item and checks them in order
  class glyph_motion_board;
    logic [23:0]        scale;
    logic signed [31:0] align_x, align_y, origin_x, origin_y;
    logic signed [15:0] cos_rot, sin_rot;
    logic signed [31:0] cursor_x, cursor_y;
    bit                 prev_draw, have_prev, first_move_pending;
    result_t            due_cmds[$];
    int unsigned        errors;

    function new();
      scale              = 24'h010000;
      align_x            = '0;
      align_y            = '0;
      cos_rot            = 16'sd16384;
      sin_rot            = '0;
      origin_x           = '0;
      origin_y           = '0;
      cursor_x           = '0;
      cursor_y           = '0;
      prev_draw          = 1'b0;
      have_prev          = 1'b0;
      first_move_pending = 1'b1;
      errors             = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] value);
      case (idx)
        REG_SCALE:   scale    = value[23:0];
        REG_ALIGN_X: align_x  = value;
        REG_ALIGN_Y: align_y  = value;
        REG_COS:     cos_rot  = value[15:0];
        REG_SIN:     sin_rot  = value[15:0];
        REG_ORG_X:   origin_x = value;
        REG_ORG_Y:   origin_y = value;
        default: ;
      endcase
    endfunction

    // Clamp to 32-bit signed, optionally excluding the most negative value
    static function longint sat_pos(longint v, bit symmetric);
      longint hi, lo;
      hi = 64'sd2147483647;
      lo = symmetric ? -hi : -hi - 1;
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
    endfunction

    function void accept_item(glyph_item_t it);
      longint  px, py, ax, ay, rx, ry, ox, oy;
      bit      plunging;
      result_t r;
      // Cursor set: no beat, restart the glyph context
      if (!it.op) begin
        cursor_x           = it.line_x;
        cursor_y           = it.line_y;
        have_prev          = 1'b0;
        first_move_pending = 1'b1;
        return;
      end
      if (it.glyph_first) begin
        have_prev          = 1'b0;
        first_move_pending = 1'b1;
      end
      px = sat_pos(longint'(it.glyph_x) * longint'(scale) + longint'(cursor_x), 1'b0);
      py = sat_pos(longint'(it.glyph_y) * longint'(scale) + longint'(cursor_y), 1'b0);
      plunging = 1'b0;
      // Pen transition beat
      r = '0;
      if (have_prev && !it.draw && prev_draw) begin
        r.command = CMD_RETRACT;
        due_cmds.push_back(r);
      end else if (have_prev && it.draw && !prev_draw) begin
        r.command = CMD_PLUNGE;
        due_cmds.push_back(r);
        plunging = 1'b1;
      end
      r      = '0;
      r.last = 1'b1;
      if (!it.glyph_last) begin
        // Align, rotate with round half up, then offset to the work origin
        ax = sat_pos(px + longint'(align_x), 1'b1);
        ay = sat_pos(py + longint'(align_y), 1'b1);
        rx = (longint'(cos_rot) * ax - longint'(sin_rot) * ay + 64'sd8192) >>> 14;
        ry = (longint'(sin_rot) * ax + longint'(cos_rot) * ay + 64'sd8192) >>> 14;
        ox = sat_pos(rx + longint'(origin_x), 1'b0);
        oy = sat_pos(ry + longint'(origin_y), 1'b0);
        r.command     = CMD_XY_MOVE;
        r.motion_word = first_move_pending ? (it.draw ? MW_FEED : MW_RAPID) : MW_MODAL;
        r.cut_feed    = plunging;
        r.out_x       = ox[31:0];
        r.out_y       = oy[31:0];
        first_move_pending = 1'b0;
        prev_draw          = it.draw;
        have_prev          = 1'b1;
      end else begin
        r.command          = CMD_GLYPH_END;
        cursor_x           = px[31:0];
        cursor_y           = py[31:0];
        prev_draw          = it.draw;
        have_prev          = 1'b0;
        first_move_pending = 1'b1;
      end
      due_cmds.push_back(r);
    endfunction

    function void check_command(result_t got);
      result_t want;
      if (due_cmds.size() == 0) begin
        $error("unexpected beat: command %0d x %h y %h", got.command, got.out_x, got.out_y);
        errors++;
        return;
      end
      want = due_cmds.pop_front();
      if (got.command !== want.command) begin
        $error("command expected %0d actual %0d", want.command, got.command);
        errors++;
      end
      if (got.motion_word !== want.motion_word) begin
        $error("motion_word expected %0d actual %0d", want.motion_word, got.motion_word);
        errors++;
      end
      if (got.cut_feed !== want.cut_feed) begin
        $error("cut_feed expected %0d actual %0d", want.cut_feed, got.cut_feed);
        errors++;
      end
      if (got.out_x !== want.out_x) begin
        $error("out_x expected %h actual %h", want.out_x, got.out_x);
        errors++;
      end
      if (got.out_y !== want.out_y) begin
        $error("out_y expected %h actual %h", want.out_y, got.out_y);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last expected %0d actual %0d", want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_DATA_W-1:0]   s_axis_tdata  = '0;
  logic [IN_TUSER_W-1:0]  s_axis_tuser  = '0;
  logic                   s_axis_tlast  = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [OUT_TUSER_W-1:0] m_axis_tuser;
  logic                   m_axis_tlast;
  logic                   psel          = 1'b0;
  logic                   penable       = 1'b0;
  logic                   pwrite        = 1'b0;
  logic [APB_ADDR_W-1:0]  paddr         = '0;
  logic [31:0]            pwdata        = '0;
  logic [31:0]            prdata;
  logic                   pready;

  glyph_motion_board motion_board = new();
  bit                no_idle      = 1'b0;
  int unsigned       items_sent   = 0;

  stroke_glyph_to_motion_commands dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #4 clk_i = ~clk_i;

  // Mostly modest font coordinates, sometimes the full range
  function automatic int rand_coord();
    if ($urandom_range(99) < 80) return int'($urandom_range(48)) - 24;
    return int'($urandom_range(255)) - 128;
  endfunction

  // Half the time positions within +-256 units, otherwise any 32-bit value
  function automatic logic [31:0] rand_pos();
    if ($urandom_range(1) == 0) return $urandom_range(32'h01FF_FFFF) - 32'h0100_0000;
    return $urandom;
  endfunction

  function automatic glyph_item_t segment(bit draw, bit first_f, bit last_f, int gx, int gy);
    glyph_item_t it;
    it.op          = 1'b1;
    it.draw        = draw;
    it.glyph_first = first_f;
    it.glyph_last  = last_f;
    it.glyph_x     = gx[7:0];
    it.glyph_y     = gy[7:0];
    it.line_x      = $urandom;
    it.line_y      = $urandom;
    return it;
  endfunction

  function automatic glyph_item_t cursor_set(logic [31:0] x, logic [31:0] y);
    glyph_item_t it;
    it             = segment($urandom_range(1), $urandom_range(1), $urandom_range(1),
                             rand_coord(), rand_coord());
    it.op          = 1'b0;
    it.line_x      = x;
    it.line_y      = y;
    return it;
  endfunction

  // Offer one beat after a random gap, hold it until accepted
  task automatic send_item(glyph_item_t it);
    while (!no_idle && $urandom_range(99) < 8) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {it.line_y, it.line_x, it.glyph_y, it.glyph_x};
    s_axis_tuser  <= {it.glyph_first, it.draw, it.op};
    s_axis_tlast  <= it.glyph_last;
    do @(posedge clk_i); while (!s_axis_tready);
    motion_board.accept_item(it);
    items_sent++;
  endtask

  // Stop sending, wait for every predicted beat, then let the block go quiet
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (motion_board.due_cmds.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic apb_write(logic [2:0] idx, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    motion_board.write_reg(idx, value);
  endtask

  // Program all registers: moderate, high extremes, full random, low extremes
  task automatic program_setting(int unsigned kind);
    logic [31:0] sc, alx, aly, cs, sn, orx, ory;
    case (kind % 4)
      0: begin
        sc  = $urandom_range(32'h0003_0000, 32'h0000_2000);
        alx = $urandom_range(32'h007F_FFFF) - 32'h0040_0000;
        aly = $urandom_range(32'h007F_FFFF) - 32'h0040_0000;
        cs  = int'($urandom_range(32768)) - 16384;
        sn  = int'($urandom_range(32768)) - 16384;
        orx = $urandom_range(32'h01FF_FFFF) - 32'h0100_0000;
        ory = $urandom_range(32'h01FF_FFFF) - 32'h0100_0000;
      end
      1: begin
        sc  = 32'h00FF_FFFF;
        alx = 32'h7FFF_FFFF;
        aly = 32'h8000_0000;
        cs  = 32'h0000_4000;
        sn  = 32'hFFFF_C000;
        orx = 32'h7FFF_FFFF;
        ory = 32'h8000_0000;
      end
      2: begin
        sc  = $urandom_range(32'h00FF_FFFF);
        alx = $urandom;
        aly = $urandom;
        cs  = int'($urandom_range(32768)) - 16384;
        sn  = int'($urandom_range(32768)) - 16384;
        orx = $urandom;
        ory = $urandom;
      end
      default: begin
        sc  = 32'h0000_0000;
        alx = 32'h8000_0000;
        aly = 32'h7FFF_FFFF;
        cs  = 32'hFFFF_C000;
        sn  = 32'h0000_4000;
        orx = 32'h8000_0000;
        ory = 32'h7FFF_FFFF;
      end
    endcase
    apb_write(REG_SCALE, sc);
    apb_write(REG_ALIGN_X, alx);
    apb_write(REG_ALIGN_Y, aly);
    apb_write(REG_COS, cs);
    apb_write(REG_SIN, sn);
    apb_write(REG_ORG_X, orx);
    apb_write(REG_ORG_Y, ory);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // One glyph: a leading move, random pen segments, a final advance
  task automatic send_glyph();
    int unsigned n;
    bit          draw, first_f, last_f;
    n = $urandom_range(7, 1);
    for (int unsigned i = 0; i < n; i++) begin
      draw    = (i == 0) ? ($urandom_range(9) == 0) : $urandom_range(1);
      first_f = (i == 0) && ($urandom_range(19) != 0);
      last_f  = (i == n - 1) && ($urandom_range(19) != 0);
      send_item(segment(draw, first_f, last_f, rand_coord(), rand_coord()));
    end
  endtask

  // Result side: random stalls, check each accepted beat
  initial begin
    result_t got;
    @(posedge rst_ni);
    forever begin
      m_axis_tready <= no_idle || ($urandom_range(99) >= 8);
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        got.command     = m_axis_tuser[1:0];
        got.motion_word = m_axis_tuser[3:2];
        got.cut_feed    = m_axis_tuser[4];
        got.out_x       = m_axis_tdata[31:0];
        got.out_y       = m_axis_tdata[63:32];
        got.last        = m_axis_tlast;
        motion_board.check_command(got);
      end
    end
  end

  // Stimulus
  initial begin
    int unsigned next_phase, phase, waited, pick;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: pen transitions, glyph ends, missing first flag, saturation
    send_item(cursor_set(32'h0000_0000, 32'h0000_0000));
    send_item(segment(1'b0, 1'b1, 1'b0, 0, 0));
    send_item(segment(1'b1, 1'b0, 1'b0, 127, 127));
    send_item(segment(1'b1, 1'b0, 1'b0, -128, -128));
    send_item(segment(1'b0, 1'b0, 1'b0, 5, -3));
    send_item(segment(1'b0, 1'b0, 1'b0, 1, 1));
    send_item(segment(1'b1, 1'b0, 1'b1, 10, 0));
    send_item(segment(1'b1, 1'b1, 1'b0, -128, 127));
    send_item(segment(1'b0, 1'b0, 1'b1, 12, 0));
    send_item(segment(1'b1, 1'b1, 1'b1, 7, 2));
    send_item(segment(1'b1, 1'b0, 1'b0, 3, 4));
    send_item(segment(1'b0, 1'b0, 1'b1, 9, 0));
    send_item(cursor_set(32'h7FFF_FFFF, 32'h8000_0000));
    send_item(segment(1'b0, 1'b1, 1'b0, 127, -128));
    send_item(segment(1'b1, 1'b0, 1'b0, -128, 127));
    send_item(segment(1'b1, 1'b0, 1'b1, -128, 127));
    send_item(segment(1'b0, 1'b1, 1'b0, 2, 2));
    send_item(segment(1'b1, 1'b0, 1'b0, 4, 4));
    send_item(cursor_set(32'h0001_0000, 32'hFFFF_0000));
    send_item(segment(1'b1, 1'b0, 1'b0, 6, -6));
    send_item(segment(1'b0, 1'b0, 1'b0, 0, 0));
    send_item(segment(1'b0, 1'b0, 1'b1, 8, 0));

    // Random glyph runs under changing register settings
    items_sent = 0;
    next_phase = 0;
    phase      = 0;
    while (items_sent < RAND_ITEMS) begin
      if (items_sent >= next_phase) begin
        settle();
        program_setting(phase);
        phase++;
        next_phase += 80;
      end
      no_idle = (items_sent >= 160) && (items_sent < 240);
      pick    = $urandom_range(99);
      if (pick < 8) begin
        send_item(cursor_set(rand_pos(), rand_pos()));
      end else if (pick < 16) begin
        send_item(segment($urandom_range(1), $urandom_range(1), $urandom_range(1),
                          int'($urandom_range(255)), int'($urandom_range(255))));
      end else begin
        send_glyph();
      end
    end
    no_idle = 1'b0;

    // Drain, then look for stray beats
    s_axis_tvalid <= 1'b0;
    waited = 0;
    while (motion_board.due_cmds.size() != 0 && waited < 20000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (SETTLE_CYC) @(posedge clk_i);
    if (motion_board.due_cmds.size() != 0) begin
      $error("%0d predicted beats never arrived", motion_board.due_cmds.size());
      motion_board.errors++;
    end
    if (motion_board.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #4_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/sgm_pkg.sv
rtl/sgm_cfg_regs.sv
rtl/sgm_ctrl.sv
rtl/sgm_datapath.sv
rtl/sgm_out_reg.sv
rtl/stroke_glyph_to_motion_commands.sv
rtl/sgm_checker.sv
tb/sv/tb_stroke_glyph_to_motion_commands.sv
